// File: sv/spc_pkg.sv
// Shared types and constants for the scanline pixel composer.
package spc_pkg;

    typedef enum logic [1:0] {
        MODE_MAP    = 2'd0,
        MODE_TILE   = 2'd1,
        MODE_SPRITE = 2'd2,
        MODE_RENDER = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_LCDC  = 3'd0,
        REG_SCX   = 3'd1,
        REG_SCY   = 3'd2,
        REG_BGP   = 3'd3,
        REG_OBP0  = 3'd4,
        REG_OBP1  = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BG_MAP,
        ST_BG_PIX,
        ST_BG_DONE,
        ST_SPR_READ,
        ST_SPR_PIX,
        ST_SPR_APPLY,
        ST_OUT
    } state_t;

    localparam int MAP_DEPTH      = 2048;
    localparam int MAP_ROW_TILES  = 32;
    localparam int MAP_BANK_BASE  = 1024;
    localparam int TILE_SET_LOW   = 256;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] x;
        logic [8:0] tile;
        logic [4:0] flags;
    } sprite_t;

    function automatic logic [1:0] pal_lookup(input logic [7:0] pal, input logic [1:0] color);
        logic [1:0] r;
        begin
            case (color)
                2'd0:    r = pal[1:0];
                2'd1:    r = pal[3:2];
                2'd2:    r = pal[5:4];
                default: r = pal[7:6];
            endcase
            return r;
        end
    endfunction

endpackage

// File: sv/scanline_pixel_composer.sv
// Top level of the scanline pixel composer.
// A map, tile pixel or sprite write word is taken in one cycle and worked in the next; a render
// word whose column is off screen is dropped in the same way, without a result.
// A render word spends three steps on the background (map read, pixel read, palette), then three
// steps per sprite slot through one tile-pixel read port shared with the background and one
// sprite palette unit, then presents the shade until it is taken and returns to idle. With
// sprites off or tall sprites selected the sprite steps are skipped. The single pixel memory
// port makes the sprite slots run one after another. The block takes one word at a time and the
// result stays in an output register until taken.
module scanline_pixel_composer #(
    parameter int SPRITE_COUNT = 40,
    parameter int SCREEN_WIDTH = 160,
    parameter int TILE_COUNT   = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [10:0] index,
    input  logic [7:0]  row,
    input  logic [7:0]  column,
    input  logic [8:0]  value,
    input  logic [4:0]  flags,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  pixel_shade,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int TW = $clog2(TILE_COUNT);
    localparam int PW = TW + 6;
    localparam int PIX_DEPTH = TILE_COUNT * 64;

    logic [7:0] lcdc_reg, scx_reg, scy_reg, bgp_reg, obp0_reg, obp1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg <= '0; scx_reg <= '0; scy_reg <= '0;
            bgp_reg  <= '0; obp0_reg <= '0; obp1_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spc_pkg::REG_LCDC: lcdc_reg <= cfg_data;
                spc_pkg::REG_SCX:  scx_reg  <= cfg_data;
                spc_pkg::REG_SCY:  scy_reg  <= cfg_data;
                spc_pkg::REG_BGP:  bgp_reg  <= cfg_data;
                spc_pkg::REG_OBP0: obp0_reg <= cfg_data;
                spc_pkg::REG_OBP1: obp1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    spc_pkg::state_t state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [10:0] index_reg;
    logic [7:0]  row_reg, col_reg;
    logic [8:0]  value_reg;
    logic [4:0]  flags_reg;
    logic [1:0]  shade_reg, shade_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          last_slot;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // background coordinates
    logic [7:0]  bx, by;
    logic [10:0] map_addr;
    assign bx = scx_reg + col_reg;
    assign by = scy_reg + row_reg;
    assign map_addr = {lcdc_reg[3], by[7:3], bx[7:3]};

    // tile map memory
    logic [7:0] map_mem [spc_pkg::MAP_DEPTH];
    logic [7:0] map_rd_reg;
    logic       map_we;
    assign map_we = (state_reg == spc_pkg::ST_IDLE) ? 1'b0 :
                    (state_reg == spc_pkg::ST_BG_MAP && mode_reg == spc_pkg::MODE_MAP);

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[index_reg] <= value_reg[7:0];
        map_rd_reg <= map_mem[map_addr];
    end

    // sprite table
    spc_pkg::sprite_t spr_wr, spr_rd;
    logic spr_we;
    assign spr_wr = '{y: row_reg, x: col_reg, tile: value_reg, flags: flags_reg};
    assign spr_we = (state_reg == spc_pkg::ST_BG_MAP) && (mode_reg == spc_pkg::MODE_SPRITE)
                    && ({21'd0, index_reg} < 32'(SPRITE_COUNT));

    spc_sprite_table #(.SPRITE_COUNT(SPRITE_COUNT)) u_sprites (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (spr_we),
        .wr_slot (index_reg[SW-1:0]),
        .wr_data (spr_wr),
        .rd_slot (slot_reg),
        .rd_data (spr_rd)
    );

    // sprite hit test on the registered entry
    logic [8:0] dy9, dx9;
    logic       spr_hit;
    logic [2:0] sdy, sdx;
    assign dy9 = {1'b0, row_reg} - {1'b0, spr_rd.y};
    assign dx9 = {1'b0, col_reg} - {1'b0, spr_rd.x};
    assign spr_hit = spr_rd.flags[0] && (dy9[8:3] == 6'd0) && (dx9[8:3] == 6'd0);
    assign sdy = spr_rd.flags[2] ? ~dy9[2:0] : dy9[2:0];
    assign sdx = spr_rd.flags[1] ? ~dx9[2:0] : dx9[2:0];

    logic       hit_reg;
    logic [4:0] sflags_reg;

    // shared tile pixel port
    logic [1:0] pix_mem [PIX_DEPTH];
    logic [1:0] pix_rd_reg;
    logic       pix_oor_reg;
    logic [9:0] rd_tile;
    logic [2:0] rd_r, rd_c;
    logic       pix_we;
    logic       column_ok;

    always_comb
    begin
        if (state_reg == spc_pkg::ST_BG_PIX)
        begin
            rd_tile = lcdc_reg[4] ? {2'b00, map_rd_reg} :
                      (10'(map_rd_reg) + 10'(spc_pkg::TILE_SET_LOW));
            rd_r = by[2:0];
            rd_c = bx[2:0];
        end
        else
        begin
            rd_tile = {1'b0, spr_rd.tile};
            rd_r = sdy;
            rd_c = sdx;
        end
    end

    assign column_ok = col_reg < 8'd8;
    assign pix_we = (state_reg == spc_pkg::ST_BG_MAP) && (mode_reg == spc_pkg::MODE_TILE)
                    && ({21'd0, index_reg} < 32'(TILE_COUNT))
                    && (row_reg < 8'd8) && (column_ok);

    logic [PW-1:0] wr_paddr, rd_paddr;
    assign wr_paddr = {index_reg[TW-1:0], row_reg[2:0], col_reg[2:0]};
    assign rd_paddr = {rd_tile[TW-1:0], rd_r, rd_c};

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[wr_paddr] <= value_reg[1:0];
        pix_rd_reg  <= pix_mem[rd_paddr];
        pix_oor_reg <= (32'(rd_tile) >= 32'(TILE_COUNT));
        hit_reg     <= spr_hit;
        sflags_reg  <= spr_rd.flags;
    end

    logic [1:0] color;
    assign color = pix_oor_reg ? 2'd0 : pix_rd_reg;

    logic [1:0] spr_shade;
    assign spr_shade = spc_pkg::pal_lookup(sflags_reg[4] ? obp1_reg : obp0_reg, color);

    assign last_slot = (32'(slot_reg) == SPRITE_COUNT - 1);
    logic spr_on;
    assign spr_on = lcdc_reg[1] && !lcdc_reg[2];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spc_pkg::ST_IDLE:
                if (in_fire) state_next = spc_pkg::ST_BG_MAP;
            spc_pkg::ST_BG_MAP:
                if (mode_reg != spc_pkg::MODE_RENDER)
                    state_next = spc_pkg::ST_IDLE;
                else if (32'(col_reg) >= SCREEN_WIDTH)
                    state_next = spc_pkg::ST_IDLE;
                else
                    state_next = spc_pkg::ST_BG_PIX;
            spc_pkg::ST_BG_PIX:   state_next = spc_pkg::ST_BG_DONE;
            spc_pkg::ST_BG_DONE:
                state_next = spr_on ? spc_pkg::ST_SPR_READ : spc_pkg::ST_OUT;
            spc_pkg::ST_SPR_READ: state_next = spc_pkg::ST_SPR_PIX;
            spc_pkg::ST_SPR_PIX:  state_next = spc_pkg::ST_SPR_APPLY;
            spc_pkg::ST_SPR_APPLY:
                state_next = last_slot ? spc_pkg::ST_OUT : spc_pkg::ST_SPR_READ;
            spc_pkg::ST_OUT:
                if (out_ready) state_next = spc_pkg::ST_IDLE;
            default: state_next = spc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        shade_next = shade_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            spc_pkg::ST_BG_MAP: slot_next = '0;
            spc_pkg::ST_BG_DONE:
                shade_next = lcdc_reg[0] ? spc_pkg::pal_lookup(bgp_reg, color) : 2'd0;
            spc_pkg::ST_SPR_APPLY:
            begin
                if (hit_reg)
                begin
                    if (sflags_reg[3])
                    begin
                        if (shade_reg == 2'd0) shade_next = spr_shade;
                    end
                    else if (color != 2'd0)
                        shade_next = spr_shade;
                end
                if (!last_slot) slot_next = slot_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spc_pkg::ST_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            index_reg <= index;
            row_reg   <= row;
            col_reg   <= column;
            value_reg <= value;
            flags_reg <= flags;
        end
        shade_reg <= shade_next;
    end

    assign in_ready    = (state_reg == spc_pkg::ST_IDLE);
    assign out_valid   = (state_reg == spc_pkg::ST_OUT);
    assign pixel_shade = shade_reg;

`ifndef SYNTHESIS
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_shade))
        else $error("shade changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("ready while a result waits");
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spc_pkg::ST_BG_MAP && mode_reg != spc_pkg::MODE_RENDER |=> !out_valid)
        else $error("result from a write word");
`endif
endmodule

// File: sv/spc_sprite_table.sv
// Sprite attribute table with per-slot valid bits, one registered read port.
module spc_sprite_table #(
    parameter int SPRITE_COUNT = 40,
    parameter int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [SW-1:0]     wr_slot,
    input  spc_pkg::sprite_t  wr_data,
    input  logic [SW-1:0]     rd_slot,
    output spc_pkg::sprite_t  rd_data
);
    spc_pkg::sprite_t mem [SPRITE_COUNT];
    logic [SPRITE_COUNT-1:0] valid_reg;
    logic                    rd_valid_reg;
    spc_pkg::sprite_t        rd_mem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_slot] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_slot] <= wr_data;
        rd_mem_reg <= mem[rd_slot];
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;
endmodule
